FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lct_pkg.sv
// ---------------------------------------------------------------------------
// LRU cache table package
// Shared types and constants for the LRU key/value table.
// ---------------------------------------------------------------------------
package lct_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int WORD_W      = 32;
   localparam int CAP_W       = 5;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [CAP_W-1:0]         cap_type;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   localparam word_type READ_MISS_VALUE = -32'sd1;

endpackage

FILE: sv/lct_req_if.sv
// ---------------------------------------------------------------------------
// LRU cache table request channel
// Valid/ready channel that carries one get or put request per beat.
// ---------------------------------------------------------------------------
interface lct_req_if;
   import lct_pkg::*;

   logic     valid;
   logic     ready;
   op_type   operation;
   word_type lookup_key;
   word_type write_value;

   modport source (output valid, operation, lookup_key, write_value, input ready);
   modport sink   (input valid, operation, lookup_key, write_value, output ready);

endinterface

FILE: sv/lct_rsp_if.sv
// ---------------------------------------------------------------------------
// LRU cache table response channel
// Valid/ready channel that carries one lookup result per beat.
// ---------------------------------------------------------------------------
interface lct_rsp_if;
   import lct_pkg::*;

   logic     valid;
   logic     ready;
   logic     hit;
   word_type read_value;
   logic     evicted;
   word_type evicted_key;

   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);

endinterface

FILE: sv/lru_cache_table_top.sv
// A request beat passes through the request register, then the response register.
// One request per cycle unless stalled; all ENTRIES slots compare and age in parallel.
// The request register advances whenever the response register is free or being taken.
// Reset clears all valid marks, the entry count and both stage valid flags at once.
// ---------------------------------------------------------------------------
// LRU cache table top level
// Fully associative key/value table with least recently used replacement.
// Each slot keeps an age; valid slots always hold ages 0 .. count-1 once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_cache_table_top #(
   parameter int ENTRIES = lct_pkg::ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   lct_req_if.sink              req_bus,
   lct_rsp_if.source            rsp_bus,
   input  logic                 csr_wr_en,
   input  lct_pkg::cap_type     csr_wr_data
);
   import lct_pkg::*;

   localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef logic [AGE_W-1:0] age_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Request register
   logic     req_valid_ff;
   op_type   op_ff;
   word_type key_ff;
   word_type wval_ff;

   // Response register
   logic     rsp_valid_ff;
   logic     rsp_hit_ff;
   word_type rsp_read_ff;
   logic     rsp_evicted_ff;
   word_type rsp_evkey_ff;

   // Table state
   word_type            entry_key_ff  [ENTRIES];
   word_type            entry_data_ff [ENTRIES];
   age_type             entry_age_ff  [ENTRIES];
   logic [ENTRIES-1:0]  entry_valid_ff;
   logic [ENTRIES-1:0]  entry_valid_in;
   cnt_type             count_ff;
   cnt_type             count_in;
   cnt_type             cap_ff;
   cnt_type             cap_in;
   logic [CMP_W-1:0]    cap_wide;

   // Lane logic
   logic [ENTRIES-1:0]  hit_vec;
   logic [ENTRIES-1:0]  ev_vec;
   logic [ENTRIES-1:0]  free_vec;
   logic [ENTRIES-1:0]  dst_vec;
   logic [ENTRIES-1:0]  data_we;
   age_type             age_touch [ENTRIES];
   age_type             age_in    [ENTRIES];
   age_type             hit_age;
   age_type             oldest_age;
   word_type            hit_data;
   word_type            ev_key;
   logic                hit_any;
   logic                is_put;
   logic                ev_cond;
   logic                advance;
   word_type            read_in;

   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.hit         = rsp_hit_ff;
   assign rsp_bus.read_value  = rsp_read_ff;
   assign rsp_bus.evicted     = rsp_evicted_ff;
   assign rsp_bus.evicted_key = rsp_evkey_ff;

   // Capacity is clamped to 1 .. ENTRIES when it is written.
   always_comb begin
      cap_wide = CMP_W'(csr_wr_data);
      if (cap_wide == '0) begin
         cap_wide = CMP_W'(1);
      end else if (cap_wide > CMP_W'(ENTRIES)) begin
         cap_wide = CMP_W'(ENTRIES);
      end
      cap_in = CNT_W'(cap_wide);
   end

   // Parallel compare, touch and eviction over all slots.
   always_comb begin
      is_put     = (op_ff == OP_PUT);
      oldest_age = AGE_W'(count_ff - CNT_W'(1));
      hit_age    = '0;
      hit_data   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = entry_valid_ff[i] && (entry_key_ff[i] == key_ff);
         if (hit_vec[i]) begin
            hit_age  = hit_age | entry_age_ff[i];
            hit_data = hit_data | entry_data_ff[i];
         end
      end
      hit_any = |hit_vec;

      // Lowest free slot.
      free_vec = ~entry_valid_ff & (entry_valid_ff + ENTRIES'(1));

      if (is_put && hit_any) begin
         ev_cond = (count_ff > cap_ff);
      end else if (is_put) begin
         ev_cond = (count_ff >= cap_ff);
      end else begin
         ev_cond = 1'b0;
      end

      ev_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_vec[i]) begin
            age_touch[i] = '0;
         end else if (hit_any && entry_valid_ff[i] && (entry_age_ff[i] < hit_age)) begin
            age_touch[i] = entry_age_ff[i] + AGE_W'(1);
         end else begin
            age_touch[i] = entry_age_ff[i];
         end
         // The oldest slot is found after a touch, so a put hit sees fresh ages.
         ev_vec[i] = ev_cond && entry_valid_ff[i] && (age_touch[i] == oldest_age);
         if (ev_vec[i]) begin
            ev_key = ev_key | entry_key_ff[i];
         end
      end

      if (is_put && !hit_any) begin
         dst_vec = ev_cond ? ev_vec : free_vec;
      end else begin
         dst_vec = '0;
      end

      for (int i = 0; i < ENTRIES; i++) begin
         data_we[i] = is_put && (hit_vec[i] || dst_vec[i]);
         if (dst_vec[i]) begin
            age_in[i] = '0;
         end else if (is_put && !hit_any && entry_valid_ff[i]) begin
            age_in[i] = entry_age_ff[i] + AGE_W'(1);
         end else begin
            age_in[i] = age_touch[i];
         end
      end

      entry_valid_in = dst_vec | (entry_valid_ff & ~ev_vec);

      if (is_put && hit_any && ev_cond) begin
         count_in = count_ff - CNT_W'(1);
      end else if (is_put && !hit_any && !ev_cond) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end

      if (is_put) begin
         read_in = '0;
      end else if (hit_any) begin
         read_in = hit_data;
      end else begin
         read_in = READ_MISS_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         count_ff       <= '0;
         cap_ff         <= CNT_W'(ENTRIES);
      end else begin
         if (req_bus.ready) begin
            req_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            entry_valid_ff <= entry_valid_in;
            count_ff       <= count_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            cap_ff <= cap_in;
         end
      end
   end

   // Payload registers and table storage carry no reset.
   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         op_ff   <= req_bus.operation;
         key_ff  <= req_bus.lookup_key;
         wval_ff <= req_bus.write_value;
      end
      if (advance) begin
         rsp_hit_ff     <= hit_any;
         rsp_read_ff    <= read_in;
         rsp_evicted_ff <= ev_cond;
         rsp_evkey_ff   <= ev_key;
         for (int i = 0; i < ENTRIES; i++) begin
            if (dst_vec[i]) begin
               entry_key_ff[i] <= key_ff;
            end
            if (data_we[i]) begin
               entry_data_ff[i] <= wval_ff;
            end
            entry_age_ff[i] <= age_in[i];
         end
      end
   end

   `ASSERT_ALWAYS(a_count_matches, clock, reset, int'(count_ff) == $countones(entry_valid_ff), "entry count differs from valid marks")
   `ASSERT_ALWAYS(a_hit_unique, clock, reset, $onehot0(hit_vec), "key stored in more than one slot")
   `ASSERT_ALWAYS(a_evict_unique, clock, reset, $onehot0(ev_vec), "more than one slot picked as oldest")
   `ASSERT_NEXT(a_get_keeps_count, clock, reset, advance && !is_put, $stable(count_ff), "get changed the entry count")

endmodule
